/* design/cbpg_pkg.sv */
`default_nettype none

package cbpg_pkg;

  localparam int unsigned COORD_W     = 16;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned T_W         = 17;
  localparam int unsigned IN_TDATA_W  = 136;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam int unsigned MAX_SEGMENTS_DEF = 63;
  localparam int unsigned QUEUE_DEPTH_DEF  = 2;

  typedef struct packed {
    logic [IDX_W-1:0]              segs;
    logic [3:0][COORD_W-1:0]       cy;
    logic [3:0][COORD_W-1:0]       cx;
  } curve_t;

endpackage

`default_nettype wire

/* design/cubic_bezier_point_generator.sv */
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: control points, segment count
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: point, index; tlast: last point
//
// Each point runs a bit-serial divide that forms t, then twelve lerps, each a
// difference, multiply and add step, on the one shared 17x17 multiplier, then
// an output step that loads the output register.
// Reset clears all control state at once; no clearing pass. The front register
// and the curve queue take new curves while the back end works, and the back
// end holds in its output step while the output register is not taken.
`default_nettype none

module cubic_bezier_point_generator
  import cbpg_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int unsigned QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // start_x, start_y, pull_a_x, pull_a_y, pull_b_x, pull_b_y, end_x, end_y,
  // segment_count, zero pad
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // point_x, point_y, point_index, zero pad
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                        m_axis_tlast
);

  logic               f_valid;
  logic               f_ready;
  curve_t             f_data;
  logic               q_valid;
  logic               q_ready;
  curve_t             q_data;
  logic [COORD_W-1:0] px;
  logic [COORD_W-1:0] py;
  logic [IDX_W-1:0]   pidx;

  cbpg_front #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_data_o  (f_data)
  );

  cbpg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   (f_data),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_data)
  );

  cbpg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_data_i   (q_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_x_o     (px),
    .out_y_o     (py),
    .out_index_o (pidx),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - 2*COORD_W - IDX_W)'(0), pidx, py, px};

endmodule

`default_nettype wire

/* design/cbpg_front.sv */
`default_nettype none

module cbpg_front
  import cbpg_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [IN_TDATA_W-1:0] in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output curve_t                     out_data_o
);

  logic             valid_q;
  curve_t           data_q;
  curve_t           data_d;
  logic [IDX_W-1:0] count;
  logic [IDX_W-1:0] segs;

  assign count = in_data_i[8*COORD_W +: IDX_W];

  // clamp: zero becomes one, anything above the limit becomes the limit
  always_comb begin
    priority if (count == '0) begin
      segs = IDX_W'(1);
    end else if (count > IDX_W'(MAX_SEGMENTS)) begin
      segs = IDX_W'(MAX_SEGMENTS);
    end else begin
      segs = count;
    end
  end

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      data_d.cx[n] = in_data_i[(2*n)*COORD_W +: COORD_W];
      data_d.cy[n] = in_data_i[(2*n+1)*COORD_W +: COORD_W];
    end
    data_d.segs = segs;
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      data_q  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        valid_q <= 1'b1;
        data_q  <= data_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* design/cbpg_queue.sv */
`default_nettype none

module cbpg_queue
  import cbpg_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  curve_t    in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output curve_t    out_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  curve_t        entry_q [DEPTH];
  logic [PW-1:0] wr_ptr_q;
  logic [PW-1:0] rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          push;
  logic          pop;

  assign in_ready_o  = cnt_q != CW'(DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = entry_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/cbpg_back.sv */
`default_nettype none

module cbpg_back
  import cbpg_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  curve_t                       in_data_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [COORD_W-1:0]           out_x_o,
  output logic [COORD_W-1:0]           out_y_o,
  output logic [IDX_W-1:0]             out_index_o,
  output logic                         out_last_o
);

  localparam int unsigned NUM_W   = IDX_W + 16;
  localparam int unsigned DCNT_W  = $clog2(NUM_W);
  localparam int unsigned STEPS   = 12;
  localparam int unsigned STEP_W  = $clog2(STEPS);
  localparam int unsigned PROD_W  = 2 * T_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_DIFF,
    S_MUL,
    S_ADD,
    S_OUT
  } state_e;

  state_e                   state_q;
  logic [3:0][COORD_W-1:0]  cx_q;
  logic [3:0][COORD_W-1:0]  cy_q;
  logic [3:0][COORD_W-1:0]  wx_q;
  logic [3:0][COORD_W-1:0]  wy_q;
  logic [IDX_W-1:0]         segs_q;
  logic [IDX_W-1:0]         i_q;
  logic [IDX_W-1:0]         rem_q;
  logic [T_W-1:0]           quo_q;
  logic [DCNT_W-1:0]        dcnt_q;
  logic [STEP_W-1:0]        step_q;
  logic [COORD_W-1:0]       a_q;
  logic                     neg_q;
  logic [T_W-1:0]           mag_q;
  logic [PROD_W-1:0]        prod_q;
  logic                     ov_q;
  logic [COORD_W-1:0]       ox_q;
  logic [COORD_W-1:0]       oy_q;
  logic [IDX_W-1:0]         oidx_q;
  logic                     olast_q;

  logic [NUM_W-1:0]   num;
  logic               nbit;
  logic [IDX_W:0]     rem_sh;
  logic               ge;
  logic [IDX_W-1:0]   rem_nx;
  logic               ax;
  logic [STEP_W-1:0]  pos;
  logic [1:0]         k;
  logic [COORD_W-1:0] a_s;
  logic [COORD_W-1:0] b_s;
  logic [T_W-1:0]     diff;
  logic [PROD_W-1:0]  rnd;
  logic [T_W-1:0]     qv;
  logic [T_W:0]       res;
  logic               out_free;
  logic               is_last;

  // restoring division of i * 65536 by the segment count, one bit per cycle
  assign num    = {i_q, 16'd0};
  assign nbit   = num[DCNT_W'(NUM_W - 1) - dcnt_q];
  assign rem_sh = {rem_q, nbit};
  assign ge     = rem_sh >= {1'b0, segs_q};
  assign rem_nx = ge ? IDX_W'(rem_sh - {1'b0, segs_q}) : rem_sh[IDX_W-1:0];

  // lerp order per axis, in place: k = 0,1,2 then 0,1 then 0
  assign ax  = step_q >= STEP_W'(STEPS / 2);
  assign pos = ax ? step_q - STEP_W'(STEPS / 2) : step_q;

  always_comb begin
    unique case (pos)
      STEP_W'(1), STEP_W'(4): k = 2'd1;
      STEP_W'(2):             k = 2'd2;
      default:                k = 2'd0;
    endcase
  end

  always_comb begin
    unique case (k)
      2'd1: begin
        a_s = ax ? wy_q[1] : wx_q[1];
        b_s = ax ? wy_q[2] : wx_q[2];
      end
      2'd2: begin
        a_s = ax ? wy_q[2] : wx_q[2];
        b_s = ax ? wy_q[3] : wx_q[3];
      end
      default: begin
        a_s = ax ? wy_q[0] : wx_q[0];
        b_s = ax ? wy_q[1] : wx_q[1];
      end
    endcase
  end

  assign diff = {b_s[COORD_W-1], b_s} - {a_s[COORD_W-1], a_s};
  assign rnd  = prod_q + PROD_W'(32768);
  assign qv   = rnd[16 +: T_W];
  assign res  = neg_q ? {{2{a_q[COORD_W-1]}}, a_q} - {1'b0, qv}
                      : {{2{a_q[COORD_W-1]}}, a_q} + {1'b0, qv};

  assign out_free = !ov_q || out_ready_i;
  assign is_last  = i_q == segs_q;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = ov_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_index_o = oidx_q;
  assign out_last_o  = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cx_q    <= '0;
      cy_q    <= '0;
      wx_q    <= '0;
      wy_q    <= '0;
      segs_q  <= '0;
      i_q     <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      dcnt_q  <= '0;
      step_q  <= '0;
      a_q     <= '0;
      neg_q   <= 1'b0;
      mag_q   <= '0;
      prod_q  <= '0;
      ov_q    <= 1'b0;
      ox_q    <= '0;
      oy_q    <= '0;
      oidx_q  <= '0;
      olast_q <= 1'b0;
    end else begin
      if (ov_q && out_ready_i && state_q != S_OUT) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cx_q    <= in_data_i.cx;
            cy_q    <= in_data_i.cy;
            segs_q  <= in_data_i.segs;
            i_q     <= '0;
            rem_q   <= '0;
            quo_q   <= '0;
            dcnt_q  <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q  <= rem_nx;
          quo_q  <= {quo_q[T_W-2:0], ge};
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == DCNT_W'(NUM_W - 1)) begin
            wx_q    <= cx_q;
            wy_q    <= cy_q;
            step_q  <= '0;
            state_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          a_q     <= a_s;
          neg_q   <= diff[T_W-1];
          mag_q   <= diff[T_W-1] ? T_W'(-diff) : diff;
          state_q <= S_MUL;
        end
        S_MUL: begin
          prod_q  <= PROD_W'(mag_q) * PROD_W'(quo_q);
          state_q <= S_ADD;
        end
        S_ADD: begin
          if (ax) begin
            wy_q[k] <= res[COORD_W-1:0];
          end else begin
            wx_q[k] <= res[COORD_W-1:0];
          end
          step_q <= step_q + 1'b1;
          if (step_q == STEP_W'(STEPS - 1)) begin
            state_q <= S_OUT;
          end else begin
            state_q <= S_DIFF;
          end
        end
        S_OUT: begin
          if (out_free) begin
            ov_q    <= 1'b1;
            ox_q    <= wx_q[0];
            oy_q    <= wy_q[0];
            oidx_q  <= i_q;
            olast_q <= is_last;
            if (is_last) begin
              state_q <= S_IDLE;
            end else begin
              i_q     <= i_q + 1'b1;
              rem_q   <= '0;
              quo_q   <= '0;
              dcnt_q  <= '0;
              state_q <= S_DIV;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
